>>> rtl/core/kut_pkg.sv
// Shared types, constants and preset entries of the keyed user table.
package kut_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ID_W        = 32;
   localparam int PIN_W       = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int RESET_COUNT = 2;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_EDIT   = 2'd3
   } cmd_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // One stored user entry.
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PIN_W-1:0] pin;
      logic             admin;
   } entry_type;

   // Users present after reset.
   localparam entry_type PRESET_ENTRY0 = '{id: 32'd12345678, pin: 32'd12345, admin: 1'b1};
   localparam entry_type PRESET_ENTRY1 = '{id: 32'd22747207, pin: 32'd800, admin: 1'b0};

   // Request beat.
   typedef struct packed {
      cmd_type          cmd;
      logic [ID_W-1:0]  key_id;
      logic [PIN_W-1:0] pin_value;
      logic             new_admin;
      logic             requester_admin;
   } req_payload_type;

   // Response beat.
   typedef struct packed {
      logic                   ok;
      logic [PIN_W-1:0]       pin_out;
      logic                   admin_out;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_payload_type;

   // Search token that walks down the row of cells.
   typedef struct packed {
      logic             valid;
      req_payload_type  req;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      entry_type        hit_entry;
      entry_type        last_entry;
   } packet_type;

   // Write command broadcast from the controller to the cells.
   typedef struct packed {
      logic             en;
      logic             pin_only;
      logic [IDX_W-1:0] idx;
      entry_type        data;
   } write_type;

endpackage

>>> rtl/core/kut_req_if.sv
// Request channel of the keyed user table.
interface kut_req_if import kut_pkg::*;;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/kut_rsp_if.sv
// Response channel of the keyed user table.
interface kut_rsp_if import kut_pkg::*;;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/kut_cell.sv
// One table cell: holds one entry and forwards the search token to its neighbor.
module kut_cell import kut_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic [CNT_W-1:0] count,
   input  write_type        wr,
   input  packet_type       chain_rx,
   output packet_type       chain_tx
);

   entry_type  entry_ff;
   packet_type pkt_ff;
   packet_type pkt_in;
   logic       live;
   logic       is_last;

   // Slot position relative to the number of valid entries.
   assign live    = CNT_W'(cell_idx) < count;
   assign is_last = (CNT_W'(cell_idx) + CNT_W'(1)) == count;

   // Compare the token key with this entry and pick up the last valid entry.
   always_comb begin
      pkt_in = chain_rx;
      if (chain_rx.valid && live && !chain_rx.hit && entry_ff.id == chain_rx.req.key_id) begin
         pkt_in.hit       = 1'b1;
         pkt_in.hit_idx   = cell_idx;
         pkt_in.hit_entry = entry_ff;
      end
      if (is_last) begin
         pkt_in.last_entry = entry_ff;
      end
   end

   // Token stage toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff.valid <= 1'b0;
      end else begin
         pkt_ff <= pkt_in;
      end
   end

   assign chain_tx = pkt_ff;

   // Entry storage; the first two slots hold the preset users after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         if (cell_idx == IDX_W'(0)) begin
            entry_ff <= PRESET_ENTRY0;
         end else if (cell_idx == IDX_W'(1)) begin
            entry_ff <= PRESET_ENTRY1;
         end
      end else if (wr.en && wr.idx == cell_idx) begin
         if (wr.pin_only) begin
            entry_ff.pin <= wr.data.pin;
         end else begin
            entry_ff <= wr.data;
         end
      end
   end

endmodule

>>> rtl/core/keyed_user_table.sv
// Top level of the keyed user table: controller, row of cells and response register.
//
//   Channel   Dir  Handshake            Beat contents
//   req_bus   in   valid/ready          cmd, key_id, pin_value, new_admin, requester_admin
//   rsp_bus   out  valid/ready          ok, pin_out, admin_out, entry_count
//
// A request walks the row of TABLE_DEPTH cells, one cell per cycle, then takes a
// finish step that writes the table and loads the response register.
// A new request is taken only in the idle state, so a request is not taken before
// the finish step of the earlier one.
// The next request is taken while an earlier response still waits; the finish step
// stalls only while the response register is full and not being read.
// Reset loads the two preset users and an entry count of two.
module keyed_user_table import kut_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   kut_req_if.sink     req_bus,
   kut_rsp_if.source   rsp_bus
);

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   packet_type      tail_ff;
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   packet_type      head_pkt;
   packet_type      chain_out;
   packet_type      pkt_link [TABLE_DEPTH];
   write_type       wr;
   write_type       wr_plan;
   logic            req_accept;
   logic            can_load;
   logic            plan_ok;
   logic [PIN_W-1:0] plan_pin;
   logic            plan_admin;
   logic [CNT_W-1:0] plan_count;
   logic [31:0]     count_wide;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign can_load   = !rsp_valid_ff || rsp_bus.ready;

   // Token injected into the first cell on a request beat.
   always_comb begin
      head_pkt            = '0;
      head_pkt.valid      = req_accept;
      head_pkt.req        = req_bus.payload;
   end

   // Row of cells.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         kut_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (IDX_W'(i)),
            .count    (count_ff),
            .wr       (wr),
            .chain_rx (head_pkt),
            .chain_tx (pkt_link[i])
         );
      end else begin : g_body
         kut_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (IDX_W'(i)),
            .count    (count_ff),
            .wr       (wr),
            .chain_rx (pkt_link[i-1]),
            .chain_tx (pkt_link[i])
         );
      end
   end

   assign chain_out = pkt_link[TABLE_DEPTH-1];

   // Token leaving the last cell is held until the finish step.
   always_ff @(posedge clock) begin
      if (chain_out.valid) begin
         tail_ff <= chain_out;
      end
   end

   // Outcome of the finished search.
   always_comb begin
      plan_ok    = 1'b0;
      plan_pin   = '0;
      plan_admin = 1'b0;
      plan_count = count_ff;
      wr_plan    = '0;
      case (tail_ff.req.cmd)
         CMD_LOOKUP: begin
            if (tail_ff.hit) begin
               plan_ok    = 1'b1;
               plan_pin   = tail_ff.hit_entry.pin;
               plan_admin = tail_ff.hit_entry.admin;
            end
         end
         CMD_ADD: begin
            if (tail_ff.req.requester_admin && !tail_ff.hit
                && count_ff < CNT_W'(TABLE_DEPTH)) begin
               plan_ok            = 1'b1;
               plan_count         = count_ff + CNT_W'(1);
               wr_plan.en         = 1'b1;
               wr_plan.idx        = count_ff[IDX_W-1:0];
               wr_plan.data.id    = tail_ff.req.key_id;
               wr_plan.data.pin   = tail_ff.req.pin_value;
               wr_plan.data.admin = tail_ff.req.new_admin;
            end
         end
         CMD_DELETE: begin
            if (tail_ff.req.requester_admin && tail_ff.hit) begin
               plan_ok      = 1'b1;
               plan_count   = count_ff - CNT_W'(1);
               wr_plan.en   = 1'b1;
               wr_plan.idx  = tail_ff.hit_idx;
               wr_plan.data = tail_ff.last_entry;
            end
         end
         CMD_EDIT: begin
            if (tail_ff.hit) begin
               plan_ok          = 1'b1;
               wr_plan.en       = 1'b1;
               wr_plan.pin_only = 1'b1;
               wr_plan.idx      = tail_ff.hit_idx;
               wr_plan.data.pin = tail_ff.req.pin_value;
            end
         end
         default: begin
            plan_ok = 1'b0;
         end
      endcase
   end

   assign count_wide = 32'(plan_count);

   // Next state, table write and response load.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      wr            = '0;
      req_bus.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain_out.valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (can_load) begin
               wr                 = wr_plan;
               count_in           = plan_count;
               rsp_in.ok          = plan_ok;
               rsp_in.pin_out     = plan_pin;
               rsp_in.admin_out   = plan_admin;
               rsp_in.entry_count = count_wide[COUNT_OUT_W-1:0];
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(RESET_COUNT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // The entry count never exceeds the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // A token leaves the row only while the controller waits for it.
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain_out.valid |-> state_ff == ST_SCAN)
      else $error("search token left the row outside a scan");

   // A request beat starts a scan.
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_SCAN)
      else $error("request beat did not start a scan");

   // A successful delete lowers the count by one.
   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && can_load && plan_ok && tail_ff.req.cmd == CMD_DELETE)
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete did not lower the entry count");

   // Table writes happen only in the finish step.
   a_write_finish: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == ST_FINISH && can_load))
      else $error("table write outside the finish step");

endmodule
